// ===== rtl/assert_macros.svh =====
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Property whose consequent must hold in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tsort_pkg.sv =====
// Shared types and constants of the topological sort block.
package tsort_pkg;

  localparam int NODE_W        = 6;
  localparam int NODE_CNT      = 64;
  localparam int CNT_W         = 7;
  localparam int STAT_W        = 2;
  localparam int MAX_EDGES_DEF = 256;
  localparam int NODE_CNT_RST  = 64;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ORDER    = 2'd0,
    ST_CYCLE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_WR,
    S_PICK,
    S_HEAD,
    S_EDGE,
    S_DEC,
    S_CHECK,
    S_OSEND,
    S_RES
  } state_t;

  typedef struct packed {
    logic                load;
    logic [NODE_CNT-1:0] load_map;
    logic                set;
    logic [NODE_W-1:0]   set_idx;
    logic                take;
    logic                clear;
  } rdy_ctl_t;

endpackage

// ===== rtl/tsort_if.sv =====
// Request and result channel interfaces.
interface tsort_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [tsort_pkg::NODE_W-1:0]  edge_from;
  logic [tsort_pkg::NODE_W-1:0]  edge_to;
  modport source(output valid, req_type, edge_from, edge_to, input ready);
  modport sink(input valid, req_type, edge_from, edge_to, output ready);
endinterface

interface tsort_res_if;
  logic                          valid;
  logic                          ready;
  logic [tsort_pkg::NODE_W-1:0]  node_index;
  logic [tsort_pkg::STAT_W-1:0]  status;
  logic                          last;
  modport source(output valid, node_index, status, last, input ready);
  modport sink(input valid, node_index, status, last, output ready);
endinterface

// ===== rtl/tsort_pick.sv =====
// Ready bitmap with priority encoder that yields the smallest ready node.
module tsort_pick (
  input  logic                          clk,
  input  logic                          rst,
  input  tsort_pkg::rdy_ctl_t           ctl,
  output logic                          any,
  output logic [tsort_pkg::NODE_W-1:0]  idx
);
  import tsort_pkg::*;

  logic [NODE_CNT-1:0] ready_map;
  logic [NODE_CNT-1:0] ready_map_next;

  always_comb begin
    idx = '0;
    for (int i = NODE_CNT - 1; i >= 0; i--) begin
      if (ready_map[i]) idx = NODE_W'(i);
    end
  end

  assign any = |ready_map;

  always_comb begin
    ready_map_next = ready_map;
    if (ctl.clear) begin
      ready_map_next = '0;
    end else if (ctl.load) begin
      ready_map_next = ctl.load_map;
    end else begin
      if (ctl.take) ready_map_next[idx] = 1'b0;
      if (ctl.set) ready_map_next[ctl.set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_map <= '0;
    end else begin
      ready_map <= ready_map_next;
    end
  end

endmodule

// ===== rtl/min_first_topological_sort.sv =====
// Top level: edge store, sequencer and result port of the topological sort.
//
// Request words on req: req_type 0 adds edge edge_from -> edge_to (0-based),
// req_type 1 runs Kahn's algorithm, always taking the smallest ready node.
// Results on res: node_index in order with status 0, last set on the final
// node; a graph with a cycle gives one word with status 1, an overflowed
// edge store one word with status 2. cfg_we/cfg_data set node_count.
// An edge word is written to the store in S_EDGE_WR; one whose endpoints are
// out of range or that finds the store full is not written. A run does a
// pick and a list-head read per node taken, an edge-store read per edge
// leaving it and an in-degree update per such edge whose target is below
// node_count, all through one port per memory; then it sends one result word
// per cycle when res is ready. Overflow skips the search; its word comes next.
// req is not ready until the last result word of a run is taken; a stalled
// res holds its word. After each run the graph is cleared at once through
// the valid bits. rst (synchronous) clears the graph and sets node_count 64.
module min_first_topological_sort #(
  parameter int MAX_EDGES = tsort_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tsort_pkg::CNT_W-1:0]  cfg_data,
  tsort_req_if.sink                    req,
  tsort_res_if.source                  res
);
  import tsort_pkg::*;
  `include "assert_macros.svh"

  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int DW = EW;

  typedef logic [EA:0] link_t;

  state_t state, state_next;

  logic [CNT_W-1:0]    nc;
  logic [CNT_W-1:0]    n_eff;
  logic [EW-1:0]       et;
  logic                ovf;
  logic [CNT_W-1:0]    ot;
  logic [CNT_W-1:0]    k;
  logic [NODE_W-1:0]   cur_v;
  logic [NODE_W-1:0]   cur_u;
  logic [NODE_W-1:0]   a_q;
  logic [NODE_W-1:0]   b_q;
  link_t               nxt;
  status_t             res_stat;
  logic [NODE_CNT-1:0] hv;
  logic [NODE_CNT-1:0] dv;
  logic [NODE_CNT-1:0] node_mask;

  logic [EA-1:0]       head_mem [NODE_CNT];
  logic [DW-1:0]       deg_mem  [NODE_CNT];
  link_t               next_mem [MAX_EDGES];
  logic [NODE_W-1:0]   dest_mem [MAX_EDGES];
  logic [NODE_W-1:0]   ord_mem  [NODE_CNT];

  logic [EA-1:0]       head_q;
  logic [DW-1:0]       deg_q;
  link_t               next_q;
  logic [NODE_W-1:0]   dest_q;
  logic [NODE_W-1:0]   ord_q;

  logic [NODE_W-1:0]   head_raddr, deg_raddr, ord_raddr;
  logic [EA-1:0]       edge_raddr;
  logic                edge_we, head_we, deg_we, ord_we;
  logic [NODE_W-1:0]   deg_waddr;
  logic [DW-1:0]       deg_wdata;
  logic [DW-1:0]       deg_cur;
  logic                in_acc, out_acc, do_clear, edge_ok, edge_full;
  logic                pick_any;
  logic [NODE_W-1:0]   pick_idx;
  rdy_ctl_t            rctl;

  tsort_pick u_pick (
    .clk (clk),
    .rst (rst),
    .ctl (rctl),
    .any (pick_any),
    .idx (pick_idx)
  );

  assign n_eff = (nc == '0) ? CNT_W'(1) :
                 (nc > CNT_W'(NODE_CNT)) ? CNT_W'(NODE_CNT) : nc;

  always_comb begin
    for (int i = 0; i < NODE_CNT; i++) node_mask[i] = CNT_W'(i) < n_eff;
  end

  assign in_acc    = req.valid & req.ready;
  assign out_acc   = res.valid & res.ready;
  assign edge_ok   = ({1'b0, req.edge_from} < n_eff) && ({1'b0, req.edge_to} < n_eff);
  assign edge_full = et >= EW'(MAX_EDGES);
  assign deg_cur   = dv[cur_u] ? deg_q : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (req.req_type == REQ_RUN) state_next = ovf ? S_RES : S_PICK;
          else if (edge_ok && !edge_full) state_next = S_EDGE_WR;
        end
      end
      S_EDGE_WR: state_next = S_IDLE;
      S_PICK:    state_next = pick_any ? S_HEAD : S_CHECK;
      S_HEAD:    state_next = hv[cur_v] ? S_EDGE : S_PICK;
      S_EDGE: begin
        if ({1'b0, dest_q} < n_eff) state_next = S_DEC;
        else if (next_q[EA]) state_next = S_PICK;
      end
      S_DEC:     state_next = nxt[EA] ? S_PICK : S_EDGE;
      S_CHECK:   state_next = (ot != n_eff) ? S_RES : S_OSEND;
      S_OSEND:   if (out_acc && (k + CNT_W'(1) == ot)) state_next = S_IDLE;
      S_RES:     if (out_acc) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    req.ready      = 1'b0;
    res.valid      = 1'b0;
    res.node_index = '0;
    res.status     = ST_ORDER;
    res.last       = 1'b0;
    head_raddr     = req.edge_from;
    deg_raddr      = req.edge_to;
    edge_raddr     = next_q[EA-1:0];
    ord_raddr      = k[NODE_W-1:0];
    edge_we        = 1'b0;
    head_we        = 1'b0;
    deg_we         = 1'b0;
    deg_waddr      = b_q;
    deg_wdata      = (dv[b_q] ? deg_q : '0) + DW'(1);
    ord_we         = 1'b0;
    do_clear       = 1'b0;
    rctl           = '0;
    rctl.load_map  = ~dv & node_mask;
    rctl.set_idx   = cur_u;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        rctl.load = in_acc && (req.req_type == REQ_RUN) && !ovf;
      end
      S_EDGE_WR: begin
        edge_we = 1'b1;
        head_we = 1'b1;
        deg_we  = 1'b1;
      end
      S_PICK: begin
        head_raddr = pick_idx;
        rctl.take  = pick_any;
        ord_we     = pick_any;
      end
      S_HEAD: edge_raddr = head_q;
      S_EDGE: deg_raddr = dest_q;
      S_DEC: begin
        edge_raddr = nxt[EA-1:0];
        deg_waddr  = cur_u;
        deg_wdata  = deg_cur - DW'(1);
        deg_we     = deg_cur != '0;
        rctl.set   = deg_cur == DW'(1);
      end
      S_CHECK: ord_raddr = '0;
      S_OSEND: begin
        res.valid      = 1'b1;
        res.node_index = ord_q;
        res.last       = (k + CNT_W'(1) == ot);
        // advance the read address with the taken word
        if (out_acc) ord_raddr = k[NODE_W-1:0] + NODE_W'(1);
        do_clear       = out_acc && res.last;
      end
      S_RES: begin
        res.valid  = 1'b1;
        res.status = res_stat;
        res.last   = 1'b1;
        do_clear   = out_acc;
      end
      default: ;
    endcase
    rctl.clear = do_clear;
  end

  // memories
  always_ff @(posedge clk) begin
    if (edge_we) begin
      dest_mem[et[EA-1:0]] <= b_q;
      next_mem[et[EA-1:0]] <= hv[a_q] ? {1'b0, head_q} : {1'b1, {EA{1'b0}}};
    end
    if (head_we) head_mem[a_q] <= et[EA-1:0];
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (ord_we) ord_mem[ot[NODE_W-1:0]] <= pick_idx;
    head_q <= head_mem[head_raddr];
    deg_q  <= deg_mem[deg_raddr];
    dest_q <= dest_mem[edge_raddr];
    next_q <= next_mem[edge_raddr];
    ord_q  <= ord_mem[ord_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      a_q <= req.edge_from;
      b_q <= req.edge_to;
    end
    if (state == S_PICK) cur_v <= pick_idx;
    if (state == S_EDGE) begin
      cur_u <= dest_q;
      nxt   <= next_q;
    end
    if (state == S_IDLE) res_stat <= ST_OVERFLOW;
    else if (state == S_CHECK) res_stat <= ST_CYCLE;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nc    <= CNT_W'(NODE_CNT_RST);
      et    <= '0;
      ovf   <= 1'b0;
      ot    <= '0;
      k     <= '0;
      hv    <= '0;
      dv    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) nc <= cfg_data;
      if (state == S_IDLE && in_acc && req.req_type == REQ_EDGE && edge_ok) begin
        if (edge_full) ovf <= 1'b1;
      end
      if (edge_we) begin
        et       <= et + EW'(1);
        hv[a_q]  <= 1'b1;
        dv[b_q]  <= 1'b1;
      end
      if (ord_we) ot <= ot + CNT_W'(1);
      if (state == S_CHECK) k <= '0;
      else if (state == S_OSEND && out_acc) k <= k + CNT_W'(1);
      // drop the whole graph after the final word of a run
      if (do_clear) begin
        et  <= '0;
        ovf <= 1'b0;
        ot  <= '0;
        hv  <= '0;
        dv  <= '0;
      end
    end
  end

  `ASSERT_ALWAYS(a_order_bound, ot <= n_eff, "more nodes ordered than in use")
  `ASSERT_ALWAYS(a_dec_in_range, (state != S_DEC) || ({1'b0, cur_u} < n_eff), "decrement of node out of range")
  `ASSERT_ALWAYS(a_send_index, (state != S_OSEND) || (k < ot), "result index past order length")
  `ASSERT_NEXT(a_clear_done, do_clear, (et == '0) && (ot == '0) && !ovf && (state == S_IDLE), "graph not cleared after run")

endmodule
